[hdl/mmcs_pkg.sv]
// Package: shared constants and types of the min-max contrast stretch unit.
package mmcs_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned PixelBitsDef = 16;

  localparam int unsigned GrayW = 16;
  localparam int unsigned DimW  = 11;
  localparam int unsigned DataW = 16;

  // Configuration register indexes
  localparam logic [1:0] RegMaxGray = 2'd0;
  localparam logic [1:0] RegWidth   = 2'd1;
  localparam logic [1:0] RegHeight  = 2'd2;

  // Input action codes
  localparam logic ActLoad = 1'b0;
  localparam logic ActEmit = 1'b1;

  // Divider request: numerator, scale, divisor, flags
  typedef struct packed {
    logic [GrayW-1:0] num;
    logic [GrayW-1:0] gray;
    logic [GrayW-1:0] diff;
    logic             flat;
    logic             last;
  } div_req_t;

endpackage

[hdl/mmcs_frame_store.sv]
// Frame store: single-port synchronous pixel memory with registered read data.
module mmcs_frame_store import mmcs_pkg::*; #(
  parameter int unsigned Depth = MaxWidthDef * MaxHeightDef,
  parameter int unsigned PixW  = PixelBitsDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [PixW-1:0]  wdata_i,
  output logic [PixW-1:0]  rdata_o
);

  logic [PixW-1:0] mem_q [Depth];

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

[hdl/mmcs_divider.sv]
// Divider: multiply num by gray, then restoring division one bit per cycle.
module mmcs_divider import mmcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  div_req_t         req_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [GrayW-1:0] quot_o,
  output logic             flat_o,
  output logic             last_o
);

  localparam int unsigned ProdW = 2 * GrayW;
  localparam int unsigned CntW  = $clog2(ProdW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             mul_q, mul_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0] dvd_q, dvd_d;
  logic [GrayW:0]   rem_q, rem_d;
  logic [GrayW-1:0] dvs_q, a_q, b_q;
  logic             flat_q, last_q;
  logic [GrayW:0]   shifted;

  assign shifted = {rem_q[GrayW-1:0], dvd_q[ProdW-1]};

  // Sequencer: a multiply step, then one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mul_d  = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      mul_d  = 1'b1;
    end else if (mul_q) begin
      dvd_d = a_q * b_q;
      rem_d = '0;
      cnt_d = CntW'(ProdW);
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = shifted - {1'b0, dvs_q};
        dvd_d = {dvd_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        dvd_d = {dvd_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mul_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      mul_q  <= mul_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and quotient registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i && !busy_q) begin
      a_q    <= req_i.flat ? '0 : req_i.num;
      b_q    <= req_i.gray;
      dvs_q  <= req_i.flat ? GrayW'(1) : req_i.diff;
      flat_q <= req_i.flat;
      last_q <= req_i.last;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q[GrayW-1:0];
  assign flat_o = flat_q;
  assign last_o = last_q;

  done_after_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  no_start_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |=> mul_q == 1'b0) else $error("multiply phase too long");
  quot_fits_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> dvd_q[ProdW-1:GrayW] == '0) else $error("quotient overflow");

endmodule

[hdl/min_max_contrast_stretch_unit.sv]
// Top level: min-max contrast stretch with frame store, control and divider.
//
// Usage: input beats on s_axis (tuser = action, tdata = pixel_in). A load beat
// (action 0) writes one saturated pixel into the frame store in raster order
// and updates the running min and max; it gives no output. When
// image_width*image_height pixels are loaded the frame is full; each emit beat
// (action 1) then reads the next stored pixel and produces one beat on
// m_axis: tdata = pixel_out, tuser = {flat_frame, last_pixel}. Emits before
// the frame is full and loads after it is full are dropped.
// Timing: a load completes when its beat is accepted. An emit passes through the
// memory read, the operand registers, a multiply step and a one-bit-per-cycle
// divider into the output register. One item is in flight at a time, so no
// further beat is taken until the last result has left the output register.
// Configuration via cfg_* while idle.
// Reset: registers return to max_gray 255, 1024 x 1024, empty frame; the
// frame store is not cleared (only written entries are ever read).
// Stall: the result waits in the output register; the next input is taken
// once the output register is free.
module min_max_contrast_stretch_unit import mmcs_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef,
  parameter int unsigned PixelBits = PixelBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,   // [15:0] pixel_in
  input  logic             s_axis_tuser,   // [0] action
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,   // [15:0] pixel_out
  output logic [1:0]       m_axis_tuser,   // [0] last_pixel, [1] flat_frame
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [GrayW-1:0] cfg_data
);

  localparam int unsigned Depth = MaxWidth * MaxHeight;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [GrayW-1:0] PixMax = GrayW'((64'd1 << PixelBits) - 1);

  // Control states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [GrayW-1:0] gray_q;
  logic [DimW-1:0]  width_q, height_q;
  logic [GrayW-1:0] min_q, max_q;
  logic [CntW-1:0]  load_q, emit_q;
  logic             full_q;
  logic             last_q;
  logic             ovld_q;
  logic [GrayW-1:0] odata_q;
  logic [1:0]       ouser_q;

  // Effective register values
  logic [GrayW-1:0] eff_gray;
  logic [DimW-1:0]  eff_w, eff_h;
  logic [2*DimW-1:0] fsize;
  always_comb begin
    eff_gray = (gray_q == '0) ? GrayW'(1) : gray_q;
    if (eff_gray > PixMax) eff_gray = PixMax;
    eff_w = (width_q == '0) ? DimW'(1) : width_q;
    if (32'(eff_w) > MaxWidth) eff_w = DimW'(MaxWidth);
    eff_h = (height_q == '0) ? DimW'(1) : height_q;
    if (32'(eff_h) > MaxHeight) eff_h = DimW'(MaxHeight);
  end
  assign fsize = eff_w * eff_h;

  logic in_acc, is_load, full_now;
  assign s_axis_tready = (state_q == StIdle) && !ovld_q;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_load  = (s_axis_tuser == ActLoad);
  assign full_now = full_q || (load_q != '0 && 32'(load_q) >= 32'(fsize));
  assign cfg_ready = 1'b1;

  // Pixel saturation
  logic [GrayW-1:0] pix_sat;
  always_comb begin
    pix_sat = s_axis_tdata & PixMax;
    if (pix_sat > eff_gray) pix_sat = eff_gray;
  end

  logic mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [GrayW-1:0] mem_rdata;
  assign mem_we   = in_acc && is_load && !full_now && 32'(load_q) < Depth;
  assign mem_re   = in_acc && !is_load && full_now;
  assign mem_addr = mem_we ? load_q[AddrW-1:0] : emit_q[AddrW-1:0];

  mmcs_frame_store #(.Depth(Depth), .PixW(GrayW), .AddrW(AddrW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (pix_sat),
    .rdata_o (mem_rdata)
  );

  // Divider request from the read pixel
  div_req_t req;
  logic div_busy, div_done, div_flat, div_last;
  logic [GrayW-1:0] div_q;
  always_comb begin
    req.flat = (max_q <= min_q);
    req.diff = max_q - min_q;
    req.num  = (mem_rdata > min_q) ? mem_rdata - min_q : '0;
    if (req.num > req.diff) req.num = req.diff;
    req.gray = eff_gray;
    req.last = last_q;
  end

  mmcs_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == StRead),
    .req_i   (req),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_q),
    .flat_o  (div_flat),
    .last_o  (div_last)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (mem_re) state_d = StRead;
      StRead:  state_d = StDiv;
      StDiv:   if (div_done) state_d = StIdle;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      gray_q   <= GrayW'(255);
      width_q  <= DimW'(1024);
      height_q <= DimW'(1024);
      min_q    <= GrayW'(255);
      max_q    <= '0;
      load_q   <= '0;
      emit_q   <= '0;
      full_q   <= 1'b0;
      last_q   <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegMaxGray: gray_q   <= cfg_data;
          RegWidth:   width_q  <= cfg_data[DimW-1:0];
          RegHeight:  height_q <= cfg_data[DimW-1:0];
          default:    ;
        endcase
      end
      if (in_acc) begin
        full_q <= full_now;
        if (is_load && !full_now) begin
          if (32'(load_q) >= Depth) begin
            full_q <= 1'b1;
          end else begin
            load_q <= load_q + 1'b1;
            // Frame is full once the last pixel is in, whatever the size does later
            if (32'(load_q) + 32'd1 >= 32'(fsize)) full_q <= 1'b1;
            if (load_q == '0) begin
              min_q <= pix_sat;
              max_q <= pix_sat;
            end else begin
              if (pix_sat < min_q) min_q <= pix_sat;
              if (pix_sat > max_q) max_q <= pix_sat;
            end
          end
        end else if (mem_re) begin
          last_q <= (emit_q + 1'b1) >= load_q;
          emit_q <= emit_q + 1'b1;
        end
      end
      // Frame end after the final emit is read
      if (state_q == StRead && last_q) begin
        load_q <= '0;
        emit_q <= '0;
        full_q <= 1'b0;
        min_q  <= eff_gray;
        max_q  <= '0;
      end
      if (div_done) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (div_done) begin
      odata_q <= div_flat ? '0 : div_q;
      ouser_q <= {div_flat, div_last};
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  out_holds_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !m_axis_tready |=> ovld_q) else $error("result dropped");
  no_take_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !s_axis_tready) else $error("input taken while dividing");
  emit_le_load_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= load_q) else $error("emit count past load count");
  flat_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && ouser_q[1] |-> odata_q == '0) else $error("flat output not zero");

endmodule
